// ----- hdl/assert_macros.svh -----
// Concurrent assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DCWR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define DCWR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DCWR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/dcwr_pkg.sv -----
package dcwr_pkg;

	localparam int DUTY_W = 8;
	localparam int PULSE_W = 11;
	localparam int STEP_W = 6;
	localparam int WDUTY_W = 16;
	localparam int CMD_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;

	localparam int PWM_FRAME_US_DEF = 20000;

	localparam logic [PULSE_W-1:0] WEAPON_MIN_US = 11'd1000;
	localparam logic [PULSE_W-1:0] WEAPON_MAX_US = 11'd2000;
	localparam logic [PULSE_W-1:0] WEAPON_ARM_US = 11'd1100;
	localparam logic [PULSE_W-1:0] WEAPON_ON_DEF = 11'd1950;
	localparam logic [STEP_W-1:0] WEAPON_STEP_DEF = 6'd1;
	localparam logic [PULSE_W-1:0] FALL_FACTOR = 11'd20;
	localparam logic [WDUTY_W-1:0] DUTY_FULL = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_WEAPON_STEP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEAPON_ON = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_SPEED_1    = 8'h31,
		CMD_SPEED_2    = 8'h32,
		CMD_SPEED_3    = 8'h33,
		CMD_SPEED_4    = 8'h34,
		CMD_BACK       = 8'h42,
		CMD_FWD        = 8'h46,
		CMD_FWD_L      = 8'h47,
		CMD_FWD_R      = 8'h48,
		CMD_BACK_L     = 8'h49,
		CMD_BACK_R     = 8'h4A,
		CMD_SPIN_L     = 8'h4C,
		CMD_SPIN_R     = 8'h52,
		CMD_STOP       = 8'h53,
		CMD_LIGHT_ON   = 8'h55,
		CMD_WEAPON_ON  = 8'h57,
		CMD_HORN       = 8'h59,
		CMD_LIGHT_OFF  = 8'h75,
		CMD_WEAPON_OFF = 8'h77
	} cmd_code_t;

	// 0 left fwd, 1 left rev, 2 right fwd, 3 right rev
	typedef logic [3:0][DUTY_W-1:0] duty_t;

	typedef enum logic [1:0] {
		GOAL_KEEP,
		GOAL_ON,
		GOAL_OFF
	} goal_cmd_t;

	typedef struct packed {
		duty_t duty;
		logic light;
		logic horn;
	} drv_t;

	typedef struct packed {
		logic we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ----- hdl/dcwr_cmd_if.sv -----
interface dcwr_cmd_if;
	logic valid;
	logic ready;
	logic cmd_valid;
	logic [dcwr_pkg::CMD_W-1:0] cmd_byte;

	modport source (output valid, output cmd_valid, output cmd_byte, input ready);
	modport sink (input valid, input cmd_valid, input cmd_byte, output ready);
endinterface

// ----- hdl/dcwr_rsp_if.sv -----
interface dcwr_rsp_if;
	logic valid;
	logic ready;
	logic [dcwr_pkg::DUTY_W-1:0] left_fwd_duty;
	logic [dcwr_pkg::DUTY_W-1:0] left_rev_duty;
	logic [dcwr_pkg::DUTY_W-1:0] right_fwd_duty;
	logic [dcwr_pkg::DUTY_W-1:0] right_rev_duty;
	logic light_on;
	logic horn_trigger;
	logic [dcwr_pkg::PULSE_W-1:0] weapon_pulse_us;
	logic [dcwr_pkg::WDUTY_W-1:0] weapon_duty;

	modport source (
		output valid, output left_fwd_duty, output left_rev_duty,
		output right_fwd_duty, output right_rev_duty, output light_on,
		output horn_trigger, output weapon_pulse_us, output weapon_duty,
		input ready
	);
	modport sink (
		input valid, input left_fwd_duty, input left_rev_duty,
		input right_fwd_duty, input right_rev_duty, input light_on,
		input horn_trigger, input weapon_pulse_us, input weapon_duty,
		output ready
	);
endinterface

// ----- hdl/dcwr_cfg_if.sv -----
interface dcwr_cfg_if;
	logic valid;
	logic ready;
	logic [dcwr_pkg::CFG_IDX_W-1:0] index;
	logic [dcwr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/drive_command_and_weapon_ramp.sv -----
// A request accepted into stage one moves on to stage two, whose registers drive the output.
// Throughput: one request per cycle; input stalls only when both stages hold results
// and the output is not taken.
// Stage one decodes the command and steps the weapon ramp, stage two forms the servo duty.
// Reset (arst_n low, asynchronous) releases both bridges, sets speed 255, light off,
// weapon pulse and target 1100 us, step 1 us, weapon-on target 1950 us, pipeline empty.
`include "assert_macros.svh"

module drive_command_and_weapon_ramp #(
	parameter int PWM_FRAME_US = dcwr_pkg::PWM_FRAME_US_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dcwr_cmd_if.sink    cmd,
	dcwr_rsp_if.source  rsp,
	dcwr_cfg_if.sink    cfg
);
	import dcwr_pkg::*;

	logic adv1;
	logic adv2;
	logic take;

	drv_t drv_nxt;
	goal_cmd_t goal_cmd;
	cfg_wr_t cfg_wr;
	logic [PULSE_W-1:0] now_nxt;
	logic [WDUTY_W-1:0] duty_nxt;

	logic v_s1;
	drv_t drv_s1;
	logic [PULSE_W-1:0] pulse_s1;

	logic v_s2;
	drv_t drv_s2;
	logic [PULSE_W-1:0] pulse_s2;
	logic [WDUTY_W-1:0] duty_s2;

	assign adv2 = !v_s2 || rsp.ready;
	assign adv1 = !v_s1 || adv2;
	assign take = cmd.valid && adv1;
	assign cmd.ready = adv1;

	assign cfg.ready = 1'b1;
	assign cfg_wr = '{we: cfg.valid, index: cfg.index, data: cfg.data};

	dcwr_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cmd_valid (cmd.cmd_valid),
		.cmd_byte  (cmd.cmd_byte),
		.drv_nxt   (drv_nxt),
		.goal_cmd  (goal_cmd)
	);

	dcwr_ramp u_ramp (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.goal_cmd (goal_cmd),
		.cfg_wr   (cfg_wr),
		.now_nxt  (now_nxt)
	);

	dcwr_duty #(
		.PWM_FRAME_US (PWM_FRAME_US)
	) u_duty (
		.pulse_us (pulse_s1),
		.duty     (duty_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= take;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			drv_s1 <= drv_nxt;
			pulse_s1 <= now_nxt;
		end
		if (adv2 && v_s1) begin
			drv_s2 <= drv_s1;
			pulse_s2 <= pulse_s1;
			duty_s2 <= duty_nxt;
		end
	end

	assign rsp.valid = v_s2;
	assign rsp.left_fwd_duty = drv_s2.duty[0];
	assign rsp.left_rev_duty = drv_s2.duty[1];
	assign rsp.right_fwd_duty = drv_s2.duty[2];
	assign rsp.right_rev_duty = drv_s2.duty[3];
	assign rsp.light_on = drv_s2.light;
	assign rsp.horn_trigger = drv_s2.horn;
	assign rsp.weapon_pulse_us = pulse_s2;
	assign rsp.weapon_duty = duty_s2;

	`DCWR_ASSERT_IMPL(ready_when_empty_a, !v_s2, cmd.ready,
		"input held off with an empty output stage")
	`DCWR_ASSERT_NEXT(stage_moves_a, v_s1 && adv2, v_s2,
		"stage one request lost on its way to the output")

endmodule

// ----- hdl/dcwr_decode.sv -----
module dcwr_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic                        cmd_valid,
	input  logic [dcwr_pkg::CMD_W-1:0]  cmd_byte,
	output dcwr_pkg::drv_t              drv_nxt,
	output dcwr_pkg::goal_cmd_t         goal_cmd
);
	import dcwr_pkg::*;

	localparam logic [DUTY_W-1:0] SPEED_1 = 8'd65;
	localparam logic [DUTY_W-1:0] SPEED_2 = 8'd130;
	localparam logic [DUTY_W-1:0] SPEED_3 = 8'd195;
	localparam logic [DUTY_W-1:0] SPEED_4 = 8'd255;
	localparam logic [DUTY_W-1:0] ZERO = 8'd0;

	logic [DUTY_W-1:0] speed_level_q;
	duty_t duty_q;
	logic light_q;

	logic [DUTY_W-1:0] lvl;
	logic [DUTY_W-1:0] qtr;
	logic [DUTY_W-1:0] speed_nxt;

	assign lvl = speed_level_q;
	assign qtr = speed_level_q >> 2;

	always_comb begin
		drv_nxt.duty = duty_q;
		drv_nxt.light = light_q;
		drv_nxt.horn = 1'b0;
		speed_nxt = speed_level_q;
		goal_cmd = GOAL_KEEP;
		if (cmd_valid) begin
			unique case (cmd_byte)
				CMD_FWD:        drv_nxt.duty = {ZERO, lvl, ZERO, lvl};
				CMD_BACK:       drv_nxt.duty = {lvl, ZERO, lvl, ZERO};
				CMD_SPIN_L:     drv_nxt.duty = {ZERO, lvl, lvl, ZERO};
				CMD_SPIN_R:     drv_nxt.duty = {lvl, ZERO, ZERO, lvl};
				CMD_FWD_L:      drv_nxt.duty = {ZERO, lvl, ZERO, qtr};
				CMD_FWD_R:      drv_nxt.duty = {ZERO, qtr, ZERO, lvl};
				CMD_BACK_L:     drv_nxt.duty = {lvl, ZERO, qtr, ZERO};
				CMD_BACK_R:     drv_nxt.duty = {qtr, ZERO, lvl, ZERO};
				CMD_STOP:       drv_nxt.duty = '0;
				CMD_HORN:       drv_nxt.horn = 1'b1;
				CMD_LIGHT_ON:   drv_nxt.light = 1'b1;
				CMD_LIGHT_OFF:  drv_nxt.light = 1'b0;
				CMD_SPEED_1:    speed_nxt = SPEED_1;
				CMD_SPEED_2:    speed_nxt = SPEED_2;
				CMD_SPEED_3:    speed_nxt = SPEED_3;
				CMD_SPEED_4:    speed_nxt = SPEED_4;
				CMD_WEAPON_ON:  goal_cmd = GOAL_ON;
				CMD_WEAPON_OFF: goal_cmd = GOAL_OFF;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_level_q <= SPEED_4;
			duty_q <= '0;
			light_q <= 1'b0;
		end else if (take) begin
			speed_level_q <= speed_nxt;
			duty_q <= drv_nxt.duty;
			light_q <= drv_nxt.light;
		end
	end

endmodule

// ----- hdl/dcwr_ramp.sv -----
`include "assert_macros.svh"

module dcwr_ramp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  dcwr_pkg::goal_cmd_t           goal_cmd,
	input  dcwr_pkg::cfg_wr_t             cfg_wr,
	output logic [dcwr_pkg::PULSE_W-1:0]  now_nxt
);
	import dcwr_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [PULSE_W-1:0] on_q;
	logic [PULSE_W-1:0] now_q;
	logic [PULSE_W-1:0] goal_q;

	logic [PULSE_W-1:0] goal_nxt;
	logic [PULSE_W-1:0] rise;
	logic [PULSE_W-1:0] fall;
	logic [PULSE_W-1:0] diff_up;
	logic [PULSE_W-1:0] diff_dn;

	always_comb begin
		unique case (goal_cmd)
			GOAL_ON: begin
				if (on_q < WEAPON_MIN_US) begin
					goal_nxt = WEAPON_MIN_US;
				end else if (on_q > WEAPON_MAX_US) begin
					goal_nxt = WEAPON_MAX_US;
				end else begin
					goal_nxt = on_q;
				end
			end
			GOAL_OFF: goal_nxt = WEAPON_MIN_US;
			default:  goal_nxt = goal_q;
		endcase
	end

	assign rise = PULSE_W'(step_q);
	assign fall = PULSE_W'(step_q) * FALL_FACTOR;
	assign diff_up = goal_nxt - now_q;
	assign diff_dn = now_q - goal_nxt;

	always_comb begin
		priority if (now_q < goal_nxt) begin
			now_nxt = (diff_up <= rise) ? goal_nxt : now_q + rise;
		end else if (now_q > goal_nxt) begin
			now_nxt = (diff_dn <= fall) ? goal_nxt : now_q - fall;
		end else begin
			now_nxt = now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= WEAPON_STEP_DEF;
			on_q <= WEAPON_ON_DEF;
			now_q <= WEAPON_ARM_US;
			goal_q <= WEAPON_ARM_US;
		end else begin
			if (cfg_wr.we) begin
				unique case (cfg_wr.index)
					REG_WEAPON_STEP: step_q <= cfg_wr.data[STEP_W-1:0];
					REG_WEAPON_ON:   on_q <= cfg_wr.data;
					default: ;
				endcase
			end
			if (take) begin
				now_q <= now_nxt;
				goal_q <= goal_nxt;
			end
		end
	end

	`DCWR_ASSERT(goal_in_range_a, (goal_q >= WEAPON_MIN_US) && (goal_q <= WEAPON_MAX_US),
		"weapon target left its range")
	`DCWR_ASSERT_NEXT(no_overshoot_a, take && (goal_cmd == GOAL_KEEP) && (now_q <= goal_q),
		now_q <= goal_q, "weapon ramp passed its target")

endmodule

// ----- hdl/dcwr_duty.sv -----
module dcwr_duty #(
	parameter int PWM_FRAME_US = dcwr_pkg::PWM_FRAME_US_DEF
) (
	input  logic [dcwr_pkg::PULSE_W-1:0]  pulse_us,
	output logic [dcwr_pkg::WDUTY_W-1:0]  duty
);
	import dcwr_pkg::*;

	// floor(us * 65535 / frame) as a multiply by a rounded-up reciprocal, exact for 11-bit us
	localparam int FRAME_W = $clog2(PWM_FRAME_US + 1);
	localparam int SHIFT = PULSE_W + FRAME_W;
	localparam logic [63:0] RECIP =
		((64'(DUTY_FULL) << SHIFT) + 64'(PWM_FRAME_US) - 64'd1) / 64'(PWM_FRAME_US);
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = PULSE_W + RECIP_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quo;

	assign prod = PROD_W'(pulse_us) * PROD_W'(RECIP);
	assign quo = prod >> SHIFT;
	assign duty = (quo > PROD_W'(DUTY_FULL)) ? DUTY_FULL : quo[WDUTY_W-1:0];

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcwr_pkg::*;

	localparam int FRAME_US = PWM_FRAME_US_DEF;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int NUM_PHASES = 7;
	localparam int RANDOM_PHASE = 5;
	localparam int NUM_ROWS = 26;
	localparam int PAD_W = CFG_DATA_W - STEP_W;

	localparam logic [DUTY_W-1:0] LEVEL_1 = 8'd65;
	localparam logic [DUTY_W-1:0] LEVEL_2 = 8'd130;
	localparam logic [DUTY_W-1:0] LEVEL_3 = 8'd195;
	localparam logic [DUTY_W-1:0] LEVEL_4 = 8'd255;
	localparam logic [WDUTY_W-1:0] ARM_DUTY = 16'd3604;

	typedef enum logic [1:0] {
		DIR_FWD,
		DIR_REV,
		DIR_OFF
	} bridge_dir_t;

	typedef struct packed {
		logic [DUTY_W-1:0] lf;
		logic [DUTY_W-1:0] lr;
		logic [DUTY_W-1:0] rf;
		logic [DUTY_W-1:0] rr;
		logic light;
		logic horn;
		logic [PULSE_W-1:0] pulse;
		logic [WDUTY_W-1:0] wduty;
	} tick_out_t;

	typedef struct packed {
		logic cv;
		logic [CMD_W-1:0] cb;
		logic typed;
		tick_out_t want;
	} drive_row_t;

	localparam cmd_code_t DRIVE_CMDS [16] = '{
		CMD_FWD, CMD_BACK, CMD_SPIN_L, CMD_SPIN_R, CMD_FWD_L, CMD_FWD_R, CMD_BACK_L,
		CMD_BACK_R, CMD_STOP, CMD_HORN, CMD_LIGHT_ON, CMD_LIGHT_OFF, CMD_SPEED_1,
		CMD_SPEED_2, CMD_SPEED_3, CMD_SPEED_4
	};

	localparam drive_row_t DIRECTED [NUM_ROWS] = '{
		'{1'b0, 8'h00, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, WEAPON_ARM_US, ARM_DUTY}},
		'{1'b1, CMD_FWD, 1'b1,
			'{8'd255, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, WEAPON_ARM_US, ARM_DUTY}},
		'{1'b1, CMD_HORN, 1'b1,
			'{8'd255, 8'd0, 8'd255, 8'd0, 1'b0, 1'b1, WEAPON_ARM_US, ARM_DUTY}},
		'{1'b1, CMD_LIGHT_ON, 1'b1,
			'{8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 1'b0, WEAPON_ARM_US, ARM_DUTY}},
		'{1'b1, CMD_STOP, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, WEAPON_ARM_US, ARM_DUTY}},
		'{1'b1, CMD_BACK, 1'b0, '0},
		'{1'b1, CMD_SPIN_L, 1'b0, '0},
		'{1'b1, CMD_SPIN_R, 1'b0, '0},
		'{1'b1, CMD_FWD_L, 1'b0, '0},
		'{1'b1, CMD_FWD_R, 1'b0, '0},
		'{1'b1, CMD_BACK_L, 1'b0, '0},
		'{1'b1, CMD_BACK_R, 1'b0, '0},
		'{1'b1, CMD_SPEED_1, 1'b0, '0},
		'{1'b0, CMD_FWD, 1'b0, '0},
		'{1'b1, CMD_FWD_L, 1'b0, '0},
		'{1'b1, CMD_SPEED_2, 1'b0, '0},
		'{1'b1, CMD_BACK_L, 1'b0, '0},
		'{1'b1, CMD_SPEED_3, 1'b0, '0},
		'{1'b1, CMD_FWD_R, 1'b0, '0},
		'{1'b1, CMD_SPEED_4, 1'b0, '0},
		'{1'b1, CMD_BACK_R, 1'b0, '0},
		'{1'b1, CMD_LIGHT_OFF, 1'b0, '0},
		'{1'b1, CMD_WEAPON_ON, 1'b0, '0},
		'{1'b1, 8'hFF, 1'b0, '0},
		'{1'b1, CMD_WEAPON_OFF, 1'b0, '0},
		'{1'b1, 8'h00, 1'b0, '0}
	};

	localparam logic [STEP_W-1:0] PHASE_STEP [NUM_PHASES] = '{
		6'd50, 6'd1, 6'd0, 6'd63, 6'd13, 6'd1, 6'd50
	};
	localparam logic [PULSE_W-1:0] PHASE_ON [NUM_PHASES] = '{
		11'd2000, 11'd1000, 11'd1500, 11'd2047, 11'd0, 11'd1500, 11'd1950
	};

	logic clk = 1'b0;
	logic arst_n;

	dcwr_cmd_if cmd_bus ();
	dcwr_rsp_if rsp_bus ();
	dcwr_cfg_if cfg_bus ();

	drive_command_and_weapon_ramp #(
		.PWM_FRAME_US(FRAME_US)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [DUTY_W-1:0] lvl_now = LEVEL_4;
	logic [DUTY_W-1:0] spd_left = LEVEL_4;
	logic [DUTY_W-1:0] spd_right = LEVEL_4;
	logic [DUTY_W-1:0] bridge_lf = '0;
	logic [DUTY_W-1:0] bridge_lr = '0;
	logic [DUTY_W-1:0] bridge_rf = '0;
	logic [DUTY_W-1:0] bridge_rr = '0;
	logic light_now = 1'b0;
	logic [PULSE_W-1:0] pulse_now = WEAPON_ARM_US;
	logic [PULSE_W-1:0] pulse_goal = WEAPON_ARM_US;
	logic [STEP_W-1:0] step_cfg = WEAPON_STEP_DEF;
	logic [PULSE_W-1:0] on_cfg = WEAPON_ON_DEF;

	tick_out_t expected_ticks [$];
	int fail_count = 0;
	logic row_typed = 1'b0;
	tick_out_t row_want = '0;
	logic idle_on = 1'b1;
	logic long_hold_req = 1'b0;

	function automatic void load_bridges(input logic [DUTY_W-1:0] ls,
			input logic [DUTY_W-1:0] rs, input bridge_dir_t ld, input bridge_dir_t rd);
		spd_left = ls;
		spd_right = rs;
		bridge_lf = (ld == DIR_FWD) ? ls : '0;
		bridge_lr = (ld == DIR_REV) ? ls : '0;
		bridge_rf = (rd == DIR_FWD) ? rs : '0;
		bridge_rr = (rd == DIR_REV) ? rs : '0;
	endfunction

	function automatic void set_level(input logic [DUTY_W-1:0] lvl);
		lvl_now = lvl;
		spd_left = lvl;
		spd_right = lvl;
	endfunction

	function automatic tick_out_t predict_tick(input logic cv, input logic [CMD_W-1:0] cb);
		tick_out_t r;
		logic [DUTY_W-1:0] lvl;
		logic [DUTY_W-1:0] qtr;
		logic horn;
		int now_us;
		int goal_us;
		longint wd;
		lvl = lvl_now;
		qtr = lvl_now >> 2;
		horn = 1'b0;
		if (cv) begin
			case (cb)
				CMD_FWD: load_bridges(lvl, lvl, DIR_FWD, DIR_FWD);
				CMD_BACK: load_bridges(lvl, lvl, DIR_REV, DIR_REV);
				CMD_SPIN_L: load_bridges(lvl, lvl, DIR_REV, DIR_FWD);
				CMD_SPIN_R: load_bridges(lvl, lvl, DIR_FWD, DIR_REV);
				CMD_FWD_L: load_bridges(qtr, lvl, DIR_FWD, DIR_FWD);
				CMD_FWD_R: load_bridges(lvl, qtr, DIR_FWD, DIR_FWD);
				CMD_BACK_L: load_bridges(qtr, lvl, DIR_REV, DIR_REV);
				CMD_BACK_R: load_bridges(lvl, qtr, DIR_REV, DIR_REV);
				CMD_STOP: load_bridges(spd_left, spd_right, DIR_OFF, DIR_OFF);
				CMD_HORN: horn = 1'b1;
				CMD_LIGHT_ON: light_now = 1'b1;
				CMD_LIGHT_OFF: light_now = 1'b0;
				CMD_SPEED_1: set_level(LEVEL_1);
				CMD_SPEED_2: set_level(LEVEL_2);
				CMD_SPEED_3: set_level(LEVEL_3);
				CMD_SPEED_4: set_level(LEVEL_4);
				CMD_WEAPON_ON: begin
					if (on_cfg < WEAPON_MIN_US) pulse_goal = WEAPON_MIN_US;
					else if (on_cfg > WEAPON_MAX_US) pulse_goal = WEAPON_MAX_US;
					else pulse_goal = on_cfg;
				end
				CMD_WEAPON_OFF: pulse_goal = WEAPON_MIN_US;
				default: ;
			endcase
		end
		now_us = int'(pulse_now);
		goal_us = int'(pulse_goal);
		if (now_us < goal_us) begin
			now_us += int'(step_cfg);
			if (now_us > goal_us) now_us = goal_us;
		end else if (now_us > goal_us) begin
			now_us -= int'(step_cfg) * int'(FALL_FACTOR);
			if (now_us < goal_us) now_us = goal_us;
		end
		pulse_now = now_us[PULSE_W-1:0];
		wd = longint'(pulse_now) * longint'(DUTY_FULL) / FRAME_US;
		if (wd > longint'(DUTY_FULL)) wd = longint'(DUTY_FULL);
		r = '{bridge_lf, bridge_lr, bridge_rf, bridge_rr, light_now, horn, pulse_now,
			wd[WDUTY_W-1:0]};
		return r;
	endfunction

	always @(posedge clk) begin : tick_check
		tick_out_t got;
		tick_out_t want;
		tick_out_t pred;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			got = '{rsp_bus.left_fwd_duty, rsp_bus.left_rev_duty, rsp_bus.right_fwd_duty,
				rsp_bus.right_rev_duty, rsp_bus.light_on, rsp_bus.horn_trigger,
				rsp_bus.weapon_pulse_us, rsp_bus.weapon_duty};
			if (expected_ticks.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected: lf=%0d lr=%0d rf=%0d rr=%0d lt=%0b hn=%0b us=%0d d=%0d",
						got.lf, got.lr, got.rf, got.rr, got.light, got.horn, got.pulse,
						got.wduty);
			end else begin
				want = expected_ticks.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("expected: lf=%0d lr=%0d rf=%0d rr=%0d lt=%0b hn=%0b us=%0d d=%0d",
							want.lf, want.lr, want.rf, want.rr, want.light, want.horn,
							want.pulse, want.wduty);
						$display("actual:   lf=%0d lr=%0d rf=%0d rr=%0d lt=%0b hn=%0b us=%0d d=%0d",
							got.lf, got.lr, got.rf, got.rr, got.light, got.horn, got.pulse,
							got.wduty);
					end
				end
			end
		end
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			pred = predict_tick(cmd_bus.cmd_valid, cmd_bus.cmd_byte);
			expected_ticks.push_back(row_typed ? row_want : pred);
		end
	end

	task automatic send_tick(input logic cv, input logic [CMD_W-1:0] cb, input logic typed,
			input tick_out_t want);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.cmd_valid <= cv;
		cmd_bus.cmd_byte <= cb;
		row_typed = typed;
		row_want = want;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_tick();
		int pick;
		logic cv;
		logic [CMD_W-1:0] cb;
		pick = $urandom_range(0, 99);
		cv = 1'b1;
		if (pick < 12) begin
			cv = 1'b0;
			cb = CMD_W'($urandom);
		end else if (pick < 22) begin
			cb = CMD_W'($urandom);
		end else if (pick < 28) begin
			cb = ($urandom_range(0, 1) != 0) ? CMD_WEAPON_ON : CMD_WEAPON_OFF;
		end else begin
			cb = DRIVE_CMDS[$urandom_range(0, 15)];
		end
		send_tick(cv, cb, 1'b0, '0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		if (idx == REG_WEAPON_STEP) step_cfg = val[STEP_W-1:0];
		else on_cfg = val;
		@(negedge clk);
	endtask

	task automatic configure(input logic [STEP_W-1:0] step, input logic [PULSE_W-1:0] on_us);
		// pad the step write with random upper bits, which the register drops
		write_reg(REG_WEAPON_STEP, {PAD_W'($urandom), step});
		write_reg(REG_WEAPON_ON, on_us);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_ticks.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin : rsp_stall
		int stall_left;
		stall_left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8);
			end
			if (stall_left > 0) begin
				rsp_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int i;
		int p;
		logic [STEP_W-1:0] step;
		logic [PULSE_W-1:0] on_us;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.cmd_valid = 1'b0;
		cmd_bus.cmd_byte = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (i = 0; i < NUM_ROWS; i++)
			send_tick(DIRECTED[i].cv, DIRECTED[i].cb, DIRECTED[i].typed, DIRECTED[i].want);
		cmd_bus.valid <= 1'b0;
		drain();
		for (p = 0; p < NUM_PHASES; p++) begin
			step = PHASE_STEP[p];
			on_us = PHASE_ON[p];
			if (p == RANDOM_PHASE) begin
				step = STEP_W'($urandom_range(1, 50));
				on_us = PULSE_W'($urandom_range(1000, 2000));
			end
			configure(step, on_us);
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				// hold the receiver off while requests keep coming
				if (p == RANDOM_PHASE && i == 40) long_hold_req = 1'b1;
				idle_on = (p != NUM_PHASES - 1) && !(i >= 120 && i < 150);
				send_random_tick();
			end
			cmd_bus.valid <= 1'b0;
			drain();
		end
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
